@@ design/grid_astar_path_search_core_defines.svh @@
// Assertion macros used by the checker file.
`ifndef GRID_ASTAR_PATH_SEARCH_CORE_DEFINES_SVH
`define GRID_ASTAR_PATH_SEARCH_CORE_DEFINES_SVH

// Same-cycle implication, disabled while in reset.
`define GAPS_ASSERT_IMP(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("grid search check failed");

// Next-cycle implication, disabled while in reset.
`define GAPS_ASSERT_NXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("grid search check failed");

`endif

@@ design/gaps_pkg.sv @@
// Types and constants of the grid path search core.
package gaps_pkg;

	localparam int MAX_DIM = 64;
	localparam int DIM_W   = 6;
	localparam int CELL_W  = 2 * DIM_W;
	localparam int NCELL   = MAX_DIM * MAX_DIM;
	localparam int COST_W  = 12;
	localparam int EST_W   = 13;
	localparam int ORD_W   = 13;
	localparam int LEN_W   = 13;
	localparam int REG_W   = 7;

	localparam int S_DATA_W = 40;
	localparam int M_DATA_W = 32;

	localparam logic [1:0] CMD_WRITE = 2'd0;
	localparam logic [1:0] CMD_SEARCH = 2'd1;
	localparam logic [1:0] CMD_READ  = 2'd2;

	localparam logic [1:0] STAT_OK      = 2'd0;
	localparam logic [1:0] STAT_NO_PATH = 2'd1;
	localparam logic [1:0] STAT_RANGE   = 2'd2;

	localparam logic [1:0] DIR_UP    = 2'd0;
	localparam logic [1:0] DIR_DOWN  = 2'd1;
	localparam logic [1:0] DIR_LEFT  = 2'd2;
	localparam logic [1:0] DIR_RIGHT = 2'd3;

	localparam logic [7:0] REG_ROWS = 8'd0;
	localparam logic [7:0] REG_COLS = 8'd1;

	// One search node per cell.
	typedef struct packed {
		logic              open;
		logic              closed;
		logic [COST_W-1:0] cost;
		logic [EST_W-1:0]  est;
		logic [1:0]        dir;
		logic [ORD_W-1:0]  order;
	} node_t;

endpackage

@@ design/grid_astar_path_search_core.sv @@
// Top level of the grid A* path search core.
//
// channel | dir | handshake         | payload
// s_*     | in  | s_tvalid/s_tready | s_tuser command, s_tdata cell/goal/index
// m_*     | out | m_tvalid/m_tready | m_tuser status, m_tdata length/point
// cfg_*   | in  | cfg_valid/cfg_ready | cfg_index register, cfg_data value
//
// Cell write: answered from idle. Path read: through ST_RD for the path memory
// read. Search: a node clear over all cells plus an init step, then per
// expansion an open-set scan over all cells, a pick and close of the best node,
// and a read, with an update where needed, of each in-grid neighbour (off-grid
// ones are skipped); then the two back-trace passes walk from goal to start.
// After reset a pass over all map cells clears the map; s_tready stays low meanwhile.
// An input transaction is taken only when idle and the output register is free
// or draining; m_tready low holds the result and stalls further input.
module grid_astar_path_search_core (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          s_tvalid,
	output logic                          s_tready,
	// row[5:0] col[11:6] blocked[12] goal_row[18:13] goal_col[24:19]
	// path_index[36:25], zero fill [39:37]
	input  logic [gaps_pkg::S_DATA_W-1:0] s_tdata,
	// command[1:0]
	input  logic [1:0]                    s_tuser,
	output logic                          m_tvalid,
	input  logic                          m_tready,
	// path_length[12:0] point_row[18:13] point_col[24:19], zero fill [31:25]
	output logic [gaps_pkg::M_DATA_W-1:0] m_tdata,
	// status[1:0]
	output logic [1:0]                    m_tuser,
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [7:0]                    cfg_index,
	input  logic [gaps_pkg::REG_W-1:0]    cfg_data
);
	import gaps_pkg::*;

	localparam logic [3:0] ST_BOOT     = 4'd0;
	localparam logic [3:0] ST_IDLE     = 4'd1;
	localparam logic [3:0] ST_RD       = 4'd2;
	localparam logic [3:0] ST_CLR      = 4'd3;
	localparam logic [3:0] ST_INIT     = 4'd4;
	localparam logic [3:0] ST_SCAN     = 4'd5;
	localparam logic [3:0] ST_SCAN_END = 4'd6;
	localparam logic [3:0] ST_PICK     = 4'd7;
	localparam logic [3:0] ST_EXP      = 4'd8;
	localparam logic [3:0] ST_NB_ADDR  = 4'd9;
	localparam logic [3:0] ST_NB_DATA  = 4'd10;
	localparam logic [3:0] ST_LEN      = 4'd11;
	localparam logic [3:0] ST_LEN_WT   = 4'd12;
	localparam logic [3:0] ST_PW       = 4'd13;
	localparam logic [3:0] ST_PW_WT    = 4'd14;

	localparam logic [CELL_W-1:0] LAST_CELL = CELL_W'(NCELL - 1);
	localparam logic [LEN_W-1:0]  LEN_MAX   = LEN_W'(NCELL);

	// input fields
	logic [1:0]        in_cmd;
	logic [DIM_W-1:0]  in_row, in_col, in_grow, in_gcol;
	logic              in_blk;
	logic [CELL_W-1:0] in_idx;
	assign in_cmd  = s_tuser;
	assign in_row  = s_tdata[5:0];
	assign in_col  = s_tdata[11:6];
	assign in_blk  = s_tdata[12];
	assign in_grow = s_tdata[18:13];
	assign in_gcol = s_tdata[24:19];
	assign in_idx  = s_tdata[36:25];

	logic [3:0]        state_q;
	logic [CELL_W-1:0] sweep_q;
	logic [REG_W-1:0]  rows_q, cols_q;
	logic [CELL_W-1:0] start_q, goal_q;
	logic [CELL_W-1:0] scan_q, scan_idx_s1;
	logic              scan_vld_s1;
	logic              best_found_q;
	logic [CELL_W-1:0] best_idx_q;
	node_t             best_rec_q;
	logic [1:0]        dir_q;
	logic [CELL_W-1:0] nb_q;
	logic [ORD_W-1:0]  ctr_q;
	logic [CELL_W-1:0] walk_q;
	logic [LEN_W-1:0]  len_q, stored_len_q;
	logic              out_valid_q;
	logic [1:0]        out_status_q;
	logic [LEN_W-1:0]  out_len_q;
	logic [DIM_W-1:0]  out_row_q, out_col_q;

	// memories
	logic              blk_mem [NCELL];
	logic              blk_rd_q;
	logic              blk_we;
	logic [CELL_W-1:0] blk_waddr;
	logic              blk_wdata;
	node_t             node_mem [NCELL];
	node_t             node_rd_q;
	logic              node_we;
	logic [CELL_W-1:0] node_waddr, node_raddr;
	node_t             node_wdata;
	logic [CELL_W-1:0] path_mem [NCELL];
	logic [CELL_W-1:0] path_rd_q;
	logic              path_we;
	logic [CELL_W-1:0] path_waddr;

	logic acc;
	assign s_tready  = (state_q == ST_IDLE) && (!out_valid_q || m_tready);
	assign acc       = s_tvalid && s_tready;
	assign cfg_ready = 1'b1;
	assign m_tvalid  = out_valid_q;
	assign m_tuser   = out_status_q;
	assign m_tdata   = {(M_DATA_W - LEN_W - 2 * DIM_W)'(0), out_col_q, out_row_q, out_len_q};

	function automatic logic [REG_W-1:0] clamp_dim(input logic [REG_W-1:0] v);
		if (v == '0) return REG_W'(1);
		if (v > REG_W'(MAX_DIM)) return REG_W'(MAX_DIM);
		return v;
	endfunction

	function automatic logic [DIM_W-1:0] absdiff(input logic [DIM_W-1:0] a,
			input logic [DIM_W-1:0] b);
		return (a > b) ? a - b : b - a;
	endfunction

	// Step from a cell toward its parent.
	function automatic logic [CELL_W-1:0] back_step(input logic [CELL_W-1:0] pos,
			input logic [1:0] d);
		logic [DIM_W-1:0] r, c;
		r = pos[CELL_W-1:DIM_W];
		c = pos[DIM_W-1:0];
		case (d)
			DIR_UP:   r = r + DIM_W'(1);
			DIR_DOWN: r = r - DIM_W'(1);
			DIR_LEFT: c = c + DIM_W'(1);
			default:  c = c - DIM_W'(1);
		endcase
		return {r, c};
	endfunction

	// bounds of the write, search and read transactions
	logic in_ok_search, in_ok_write, in_ok_read;
	assign in_ok_write  = ({1'b0, in_row} < rows_q) && ({1'b0, in_col} < cols_q);
	assign in_ok_search = in_ok_write && ({1'b0, in_grow} < rows_q)
		&& ({1'b0, in_gcol} < cols_q);
	assign in_ok_read   = LEN_W'(in_idx) < stored_len_q;

	// result register load: immediate answers, read data, search outcome
	logic out_load;
	always_comb begin
		out_load = 1'b0;
		case (state_q)
			ST_IDLE: out_load = acc && !((in_cmd == CMD_SEARCH) && in_ok_search)
				&& !((in_cmd == CMD_READ) && in_ok_read);
			ST_RD:   out_load = 1'b1;
			ST_PICK: out_load = !best_found_q;
			ST_PW:   out_load = (len_q == LEN_W'(1));
			default: out_load = 1'b0;
		endcase
	end

	// open-set minimum candidate
	logic cand;
	assign cand = scan_vld_s1 && node_rd_q.open && (!best_found_q
		|| (node_rd_q.est < best_rec_q.est)
		|| ((node_rd_q.est == best_rec_q.est) && (node_rd_q.order < best_rec_q.order)));

	// neighbour of the expanded cell
	logic [DIM_W-1:0]  cur_r, cur_c, nr_c, nc_c;
	logic              nb_ok;
	logic [CELL_W-1:0] nb_cell;
	assign cur_r = best_idx_q[CELL_W-1:DIM_W];
	assign cur_c = best_idx_q[DIM_W-1:0];
	always_comb begin
		nr_c  = cur_r;
		nc_c  = cur_c;
		nb_ok = 1'b0;
		case (dir_q)
			DIR_UP: begin
				nb_ok = (cur_r != '0);
				nr_c  = cur_r - DIM_W'(1);
			end
			DIR_DOWN: begin
				nb_ok = ({1'b0, cur_r} + REG_W'(1)) < rows_q;
				nr_c  = cur_r + DIM_W'(1);
			end
			DIR_LEFT: begin
				nb_ok = (cur_c != '0);
				nc_c  = cur_c - DIM_W'(1);
			end
			default: begin
				nb_ok = ({1'b0, cur_c} + REG_W'(1)) < cols_q;
				nc_c  = cur_c + DIM_W'(1);
			end
		endcase
	end
	assign nb_cell = {nr_c, nc_c};

	// neighbour update values
	logic [COST_W-1:0] g_c;
	logic [EST_W-1:0]  est_new_c, est_dec_c;
	logic [DIM_W-1:0]  nb_r, nb_c;
	logic              nb_skip, nb_insert, nb_lower, nb_is_goal;
	assign nb_r       = nb_q[CELL_W-1:DIM_W];
	assign nb_c       = nb_q[DIM_W-1:0];
	assign g_c        = best_rec_q.cost + COST_W'(1);
	assign est_new_c  = EST_W'(g_c) + EST_W'(absdiff(nb_r, goal_q[CELL_W-1:DIM_W]))
		+ EST_W'(absdiff(nb_c, goal_q[DIM_W-1:0]));
	assign est_dec_c  = node_rd_q.est - EST_W'(node_rd_q.cost) + EST_W'(g_c);
	assign nb_skip    = blk_rd_q || node_rd_q.closed;
	assign nb_insert  = !nb_skip && !node_rd_q.open;
	assign nb_lower   = !nb_skip && node_rd_q.open && (g_c < node_rd_q.cost);
	assign nb_is_goal = (nb_q == goal_q);

	logic [LEN_W-1:0] len_m1;
	assign len_m1 = len_q - LEN_W'(1);

	// memory port muxes
	always_comb begin
		node_we    = 1'b0;
		node_waddr = sweep_q;
		node_wdata = '0;
		node_raddr = scan_q;
		blk_we     = 1'b0;
		blk_waddr  = sweep_q;
		blk_wdata  = 1'b0;
		path_we    = 1'b0;
		path_waddr = len_m1[CELL_W-1:0];
		case (state_q)
			ST_BOOT: blk_we = 1'b1;
			ST_IDLE: begin
				blk_we    = acc && (in_cmd == CMD_WRITE) && in_ok_write;
				blk_waddr = {in_row, in_col};
				blk_wdata = in_blk;
			end
			ST_CLR: node_we = 1'b1;
			ST_INIT: begin
				node_we    = 1'b1;
				node_waddr = start_q;
				node_wdata.open = 1'b1;
			end
			ST_EXP: begin
				node_we    = 1'b1;
				node_waddr = best_idx_q;
				node_wdata = best_rec_q;
				node_wdata.open   = 1'b0;
				node_wdata.closed = 1'b1;
			end
			ST_NB_ADDR: node_raddr = nb_cell;
			ST_NB_DATA: begin
				node_waddr = nb_q;
				node_wdata = node_rd_q;
				node_wdata.cost = g_c;
				node_wdata.dir  = dir_q;
				if (nb_insert) begin
					node_we = 1'b1;
					node_wdata.open  = 1'b1;
					node_wdata.est   = est_new_c;
					node_wdata.order = ctr_q;
				end else if (nb_lower) begin
					node_we = 1'b1;
					node_wdata.est = est_dec_c;
				end
			end
			ST_LEN: node_raddr = walk_q;
			ST_PW: begin
				node_raddr = walk_q;
				path_we    = 1'b1;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		if (blk_we) begin
			blk_mem[blk_waddr] <= blk_wdata;
		end
		blk_rd_q <= blk_mem[nb_cell];
	end

	always_ff @(posedge clk) begin
		if (node_we) begin
			node_mem[node_waddr] <= node_wdata;
		end
		node_rd_q <= node_mem[node_raddr];
	end

	always_ff @(posedge clk) begin
		if (path_we) begin
			path_mem[path_waddr] <= walk_q;
		end
		path_rd_q <= path_mem[in_idx];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_BOOT;
			sweep_q      <= '0;
			rows_q       <= REG_W'(MAX_DIM);
			cols_q       <= REG_W'(MAX_DIM);
			start_q      <= '0;
			goal_q       <= '0;
			scan_q       <= '0;
			scan_idx_s1  <= '0;
			scan_vld_s1  <= 1'b0;
			best_found_q <= 1'b0;
			best_idx_q   <= '0;
			best_rec_q   <= '0;
			dir_q        <= '0;
			nb_q         <= '0;
			ctr_q        <= '0;
			walk_q       <= '0;
			len_q        <= '0;
			stored_len_q <= '0;
			out_valid_q  <= 1'b0;
			out_status_q <= STAT_OK;
			out_len_q    <= '0;
			out_row_q    <= '0;
			out_col_q    <= '0;
		end else begin
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
			if (cfg_valid) begin
				if (cfg_index == REG_ROWS) begin
					rows_q <= clamp_dim(cfg_data);
				end else if (cfg_index == REG_COLS) begin
					cols_q <= clamp_dim(cfg_data);
				end
			end
			case (state_q)
				ST_BOOT: begin
					sweep_q <= sweep_q + CELL_W'(1);
					if (sweep_q == LAST_CELL) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (acc) begin
						out_row_q <= '0;
						out_col_q <= '0;
						out_len_q <= stored_len_q;
						case (in_cmd)
							CMD_WRITE: begin
								out_status_q <= in_ok_write ? STAT_OK : STAT_RANGE;
							end
							CMD_SEARCH: begin
								if (in_ok_search) begin
									start_q <= {in_row, in_col};
									goal_q  <= {in_grow, in_gcol};
									sweep_q <= '0;
									state_q <= ST_CLR;
								end else begin
									out_status_q <= STAT_RANGE;
								end
							end
							CMD_READ: begin
								if (in_ok_read) begin
									state_q <= ST_RD;
								end else begin
									out_status_q <= STAT_RANGE;
								end
							end
							default: begin
								out_status_q <= STAT_RANGE;
							end
						endcase
					end
				end
				ST_RD: begin
					out_status_q <= STAT_OK;
					out_row_q    <= path_rd_q[CELL_W-1:DIM_W];
					out_col_q    <= path_rd_q[DIM_W-1:0];
					state_q      <= ST_IDLE;
				end
				ST_CLR: begin
					sweep_q <= sweep_q + CELL_W'(1);
					if (sweep_q == LAST_CELL) begin
						state_q <= ST_INIT;
					end
				end
				ST_INIT: begin
					ctr_q        <= ORD_W'(1);
					scan_q       <= '0;
					scan_vld_s1  <= 1'b0;
					best_found_q <= 1'b0;
					state_q      <= ST_SCAN;
				end
				ST_SCAN, ST_SCAN_END: begin
					if (cand) begin
						best_found_q <= 1'b1;
						best_idx_q   <= scan_idx_s1;
						best_rec_q   <= node_rd_q;
					end
					if (state_q == ST_SCAN) begin
						scan_idx_s1 <= scan_q;
						scan_vld_s1 <= 1'b1;
						scan_q      <= scan_q + CELL_W'(1);
						if (scan_q == LAST_CELL) begin
							state_q <= ST_SCAN_END;
						end
					end else begin
						scan_vld_s1 <= 1'b0;
						state_q     <= ST_PICK;
					end
				end
				ST_PICK: begin
					if (best_found_q) begin
						state_q <= ST_EXP;
					end else begin
						stored_len_q <= '0;
						out_status_q <= STAT_NO_PATH;
						out_len_q    <= '0;
						state_q      <= ST_IDLE;
					end
				end
				ST_EXP: begin
					dir_q   <= DIR_UP;
					state_q <= ST_NB_ADDR;
				end
				ST_NB_ADDR: begin
					if (nb_ok) begin
						nb_q    <= nb_cell;
						state_q <= ST_NB_DATA;
					end else if (dir_q == DIR_RIGHT) begin
						scan_q       <= '0;
						best_found_q <= 1'b0;
						state_q      <= ST_SCAN;
					end else begin
						dir_q <= dir_q + 2'd1;
					end
				end
				ST_NB_DATA: begin
					if (nb_insert) begin
						ctr_q <= ctr_q + ORD_W'(1);
					end
					if (nb_insert && nb_is_goal) begin
						walk_q  <= goal_q;
						len_q   <= LEN_W'(1);
						state_q <= ST_LEN;
					end else if (dir_q == DIR_RIGHT) begin
						scan_q       <= '0;
						best_found_q <= 1'b0;
						state_q      <= ST_SCAN;
					end else begin
						dir_q   <= dir_q + 2'd1;
						state_q <= ST_NB_ADDR;
					end
				end
				// first pass: count the path length
				ST_LEN: begin
					if ((walk_q == start_q) || (len_q == LEN_MAX)) begin
						stored_len_q <= len_q;
						walk_q       <= goal_q;
						state_q      <= ST_PW;
					end else begin
						state_q <= ST_LEN_WT;
					end
				end
				ST_LEN_WT: begin
					walk_q  <= back_step(walk_q, node_rd_q.dir);
					len_q   <= len_q + LEN_W'(1);
					state_q <= ST_LEN;
				end
				// second pass: store points from goal back to start
				ST_PW: begin
					len_q <= len_m1;
					if (len_q == LEN_W'(1)) begin
						out_status_q <= STAT_OK;
						out_len_q    <= stored_len_q;
						state_q      <= ST_IDLE;
					end else if (walk_q != start_q) begin
						state_q <= ST_PW_WT;
					end
				end
				ST_PW_WT: begin
					walk_q  <= back_step(walk_q, node_rd_q.dir);
					state_q <= ST_PW;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

endmodule

@@ design/gaps_chk.sv @@
// Port-level checker of the grid path search core, with its bind.
`include "grid_astar_path_search_core_defines.svh"

module gaps_chk (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          s_tvalid,
	input logic                          s_tready,
	input logic                          m_tvalid,
	input logic                          m_tready,
	input logic [gaps_pkg::M_DATA_W-1:0] m_tdata,
	input logic [1:0]                    m_tuser
);
	import gaps_pkg::*;

	`GAPS_ASSERT_NXT(a_out_hold, m_tvalid && !m_tready, m_tvalid)
	`GAPS_ASSERT_IMP(a_status_code, m_tvalid, m_tuser <= STAT_RANGE)
	`GAPS_ASSERT_IMP(a_no_path_len, m_tvalid && (m_tuser == STAT_NO_PATH), m_tdata[12:0] == '0)
	`GAPS_ASSERT_IMP(a_no_take_when_full, m_tvalid && !m_tready, !s_tready)

endmodule

bind grid_astar_path_search_core gaps_chk u_gaps_chk (.*);

@@ tb/tb_top.sv @@
// Self-checking testbench for the grid A* path search core.
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;
	import gaps_pkg::*;

	localparam int WATCHDOG_LIMIT = 500000;
	localparam int LONG_HOLD      = 300;
	localparam int HOLD_TRIGGER   = 400;
	localparam int NUM_PHASES     = 24;
	// A register index past the end of the register list; the core ignores it.
	localparam logic [7:0] REG_UNUSED = 8'hFF;
	localparam logic [1:0] CMD_BAD    = 2'd3;

	typedef struct {
		logic [1:0]  cmd;
		logic [5:0]  row, col;
		logic        blk;
		logic [5:0]  goal_row, goal_col;
		logic [11:0] idx;
	} request_t;

	typedef struct {
		logic [1:0]  status;
		logic [12:0] plen;
		logic [5:0]  prow, pcol;
	} answer_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [S_DATA_W-1:0] s_tdata = '0;
	logic [1:0]  s_tuser = '0;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [M_DATA_W-1:0] m_tdata;
	logic [1:0]  m_tuser;
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic [7:0]  cfg_index = '0;
	logic [REG_W-1:0] cfg_data = '0;

	grid_astar_path_search_core dut (.*);

	initial forever #10 clk = ~clk;

	request_t pending_requests[$];
	answer_t  expected_answers[$];
	int       mismatches = 0;
	int       inputs_taken = 0;

	// ---------------------------------------------------------------
	// Predictor state: the map, per-search node data and the stored path.
	// ---------------------------------------------------------------
	bit          map_blocked[NCELL];
	bit          node_open[NCELL];
	bit          node_closed[NCELL];
	int          node_cost[NCELL];
	int          node_est[NCELL];
	logic [1:0]  node_dir[NCELL];
	int          node_order[NCELL];
	int          path_cells[NCELL];
	int          path_len = 0;
	int          rows_used = MAX_DIM;
	int          cols_used = MAX_DIM;

	function automatic int clamp_dim(logic [REG_W-1:0] v);
		if (v == 0) return 1;
		if (v > MAX_DIM) return MAX_DIM;
		return int'(v);
	endfunction

	function automatic int gap_of(int a, int b);
		return (a > b) ? a - b : b - a;
	endfunction

	function automatic int step_back(int pos);
		case (node_dir[pos])
			DIR_UP:   return pos + MAX_DIM;
			DIR_DOWN: return pos - MAX_DIM;
			DIR_LEFT: return pos + 1;
			default:  return pos - 1;
		endcase
	endfunction

	// Returns 1 when the goal enters the open set.
	function automatic bit astar_reaches_goal(int sr, int sc, int gr, int gc);
		int cur, best, r, c, nr, nc, n, g, h, ins_count;
		logic [1:0] d;
		for (int i = 0; i < NCELL; i++) begin
			node_open[i] = 0;
			node_closed[i] = 0;
		end
		ins_count = 0;
		cur = sr * MAX_DIM + sc;
		node_open[cur] = 1;
		node_cost[cur] = 0;
		node_est[cur] = 0;
		node_dir[cur] = DIR_UP;
		node_order[cur] = ins_count++;
		while (1) begin
			best = -1;
			for (int i = 0; i < NCELL; i++) begin
				if (node_open[i] && (best < 0 || node_est[i] < node_est[best] ||
				    (node_est[i] == node_est[best] && node_order[i] < node_order[best])))
					best = i;
			end
			if (best < 0) return 0;
			cur = best;
			node_open[cur] = 0;
			node_closed[cur] = 1;
			r = cur / MAX_DIM;
			c = cur % MAX_DIM;
			for (int k = 0; k < 4; k++) begin
				d = k[1:0];
				nr = r;
				nc = c;
				case (d)
					DIR_UP:    begin if (r == 0) continue; nr = r - 1; end
					DIR_DOWN:  begin if (r + 1 >= rows_used) continue; nr = r + 1; end
					DIR_LEFT:  begin if (c == 0) continue; nc = c - 1; end
					default:   begin if (c + 1 >= cols_used) continue; nc = c + 1; end
				endcase
				n = nr * MAX_DIM + nc;
				if (map_blocked[n] || node_closed[n]) continue;
				g = node_cost[cur] + 1;
				if (!node_open[n]) begin
					node_cost[n] = g;
					node_est[n] = g + gap_of(nr, gr) + gap_of(nc, gc);
					node_dir[n] = d;
					node_order[n] = ins_count++;
					node_open[n] = 1;
					if (nr == gr && nc == gc) return 1;
				end else if (g < node_cost[n]) begin
					h = node_est[n] - node_cost[n];
					node_cost[n] = g;
					node_est[n] = g + h;
					node_dir[n] = d;
				end
			end
		end
	endfunction

	function automatic void record_path(int start, int goal);
		int pos, len;
		len = 1;
		pos = goal;
		while (pos != start && len < NCELL) begin
			pos = step_back(pos);
			len++;
		end
		path_len = len;
		pos = goal;
		for (int k = len; k > 0; k--) begin
			path_cells[k-1] = pos;
			if (pos != start) pos = step_back(pos);
		end
	endfunction

	function automatic answer_t answer_for(request_t q);
		answer_t a;
		a.status = STAT_RANGE;
		a.prow = 0;
		a.pcol = 0;
		case (q.cmd)
			CMD_WRITE: if (q.row < rows_used && q.col < cols_used) begin
				map_blocked[q.row * MAX_DIM + q.col] = q.blk;
				a.status = STAT_OK;
			end
			CMD_SEARCH: if (q.row < rows_used && q.col < cols_used &&
			                q.goal_row < rows_used && q.goal_col < cols_used) begin
				if (astar_reaches_goal(q.row, q.col, q.goal_row, q.goal_col)) begin
					record_path(q.row * MAX_DIM + q.col, q.goal_row * MAX_DIM + q.goal_col);
					a.status = STAT_OK;
				end else begin
					path_len = 0;
					a.status = STAT_NO_PATH;
				end
			end
			CMD_READ: if (q.idx < path_len) begin
				a.prow = 6'(path_cells[q.idx] / MAX_DIM);
				a.pcol = 6'(path_cells[q.idx] % MAX_DIM);
				a.status = STAT_OK;
			end
			default: ;
		endcase
		a.plen = 13'(path_len);
		return a;
	endfunction

	// Input side: predict on every accepted transaction.
	always @(posedge clk) begin
		request_t q;
		answer_t  a;
		if (arst_n && s_tvalid && s_tready) begin
			q.cmd      = s_tuser;
			q.row      = s_tdata[5:0];
			q.col      = s_tdata[11:6];
			q.blk      = s_tdata[12];
			q.goal_row = s_tdata[18:13];
			q.goal_col = s_tdata[24:19];
			q.idx      = s_tdata[36:25];
			a = answer_for(q);
			expected_answers = {expected_answers, a};
			inputs_taken++;
		end
		if (arst_n && cfg_valid && cfg_ready) begin
			if (cfg_index == REG_ROWS) rows_used = clamp_dim(cfg_data);
			else if (cfg_index == REG_COLS) cols_used = clamp_dim(cfg_data);
		end
	end

	// Output side: compare each result transaction with the oldest prediction.
	always @(posedge clk) begin
		answer_t e;
		if (arst_n && m_tvalid && m_tready) begin
			if (expected_answers.size() == 0) begin
				$display("%0t: unexpected result status=%0d data=%h", $time, m_tuser, m_tdata);
				mismatches++;
			end else begin
				e = expected_answers.pop_front();
				if (m_tuser !== e.status || m_tdata[12:0] !== e.plen ||
				    m_tdata[18:13] !== e.prow || m_tdata[24:19] !== e.pcol ||
				    m_tdata[31:25] !== '0) begin
					$display("%0t: expected status=%0d len=%0d point=(%0d,%0d), got status=%0d len=%0d point=(%0d,%0d) fill=%h",
					         $time, e.status, e.plen, e.prow, e.pcol, m_tuser,
					         m_tdata[12:0], m_tdata[18:13], m_tdata[24:19], m_tdata[31:25]);
					mismatches++;
				end
			end
		end
	end

	// Sender: bursts of random length separated by random gaps.
	int burst_left = 4;
	int gap_left = 0;
	always @(posedge clk or negedge arst_n) begin
		request_t q;
		if (!arst_n) begin
			s_tvalid <= 1'b0;
		end else if (!s_tvalid || s_tready) begin
			if (s_tvalid) void'(pending_requests.pop_front());
			if (gap_left > 0) begin
				gap_left--;
				s_tvalid <= 1'b0;
			end else if (pending_requests.size() > 0) begin
				q = pending_requests[0];
				s_tvalid <= 1'b1;
				s_tuser <= q.cmd;
				s_tdata <= {3'b000, q.idx, q.goal_col, q.goal_row, q.blk, q.col, q.row};
				if (--burst_left <= 0) begin
					burst_left = $urandom_range(1, 40);
					gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
				end
			end else begin
				s_tvalid <= 1'b0;
			end
		end
	end

	// Receiver: alternating smooth and choppy windows, plus one long hold-off
	// while the sender keeps offering, so the core backs up to its input.
	int  rx_cycle = 0;
	int  hold_left = 0;
	bit  hold_done = 0;
	always @(posedge clk) begin
		rx_cycle++;
		if (hold_left > 0) begin
			hold_left--;
			m_tready <= 1'b0;
		end else if (!hold_done && inputs_taken >= HOLD_TRIGGER) begin
			hold_done = 1;
			hold_left = LONG_HOLD;
			m_tready <= 1'b0;
		end else if ((rx_cycle / 150) % 3 == 0) begin
			m_tready <= 1'b1;
		end else begin
			m_tready <= ($urandom_range(0, 3) != 0);
		end
	end

	// Watchdog: cycles with no transaction on any channel.
	int quiet_cycles = 0;
	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
			quiet_cycles = 0;
		else if (++quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("Mismatches found");
			$finish;
		end
	end

	function automatic void queue_request(logic [1:0] cmd, int unsigned row,
	                                      int unsigned col, int unsigned blk,
	                                      int unsigned gr, int unsigned gc,
	                                      int unsigned idx);
		request_t q;
		q.cmd = cmd; q.row = 6'(row); q.col = 6'(col); q.blk = 1'(blk);
		q.goal_row = 6'(gr); q.goal_col = 6'(gc); q.idx = 12'(idx);
		pending_requests = {pending_requests, q};
	endfunction

	task automatic wait_drained();
		while (pending_requests.size() != 0 || s_tvalid || expected_answers.size() != 0)
			@(posedge clk);
		@(posedge clk);
	endtask

	task automatic write_reg(logic [7:0] index, logic [REG_W-1:0] value);
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= index;
		cfg_data <= value;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
	endtask

	// A random phase: map fill (small grids only), stray writes, search-and-walk
	// sequences when the grid is small enough for searches to finish quickly, then random filler commands.
	task automatic fill_phase(int nr, int nc);
		int sr, sc, gr, gc, span;
		bit searchable;
		searchable = (nr * nc <= 16);
		if (searchable)
			for (int r = 0; r < nr; r++)
				for (int c = 0; c < nc; c++)
					queue_request(CMD_WRITE, r, c, $urandom_range(0, 3) == 0,
					              $urandom, $urandom, $urandom);
		for (int k = 0; k < 10; k++)
			queue_request(CMD_WRITE, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
		if (searchable) begin
			span = nr * nc;
			for (int s = 0; s < 2; s++) begin
				if ($urandom_range(0, 7) == 0) begin
					sr = $urandom_range(0, 63); sc = $urandom_range(0, 63);
					gr = $urandom_range(0, 63); gc = $urandom_range(0, 63);
				end else begin
					sr = $urandom_range(0, nr - 1); sc = $urandom_range(0, nc - 1);
					gr = $urandom_range(0, nr - 1); gc = $urandom_range(0, nc - 1);
				end
				queue_request(CMD_SEARCH, sr, sc, $urandom, gr, gc, $urandom);
				for (int i = 0; i <= span; i++)
					queue_request(CMD_READ, $urandom, $urandom, $urandom, $urandom, $urandom, i);
				queue_request(CMD_WRITE, $urandom_range(0, nr - 1), $urandom_range(0, nc - 1),
				              $urandom, $urandom, $urandom, $urandom);
			end
		end
		while (pending_requests.size() < 76) begin
			case ($urandom_range(0, 9))
				0:       queue_request(CMD_BAD, $urandom, $urandom, $urandom, $urandom,
				                       $urandom, $urandom);
				1, 2, 3: queue_request(CMD_WRITE, $urandom, $urandom, $urandom, $urandom,
				                       $urandom, $urandom);
				default: queue_request(CMD_READ, $urandom, $urandom, $urandom, $urandom,
				                       $urandom, ($urandom_range(0, 1) != 0) ?
				                       $urandom_range(0, 20) : $urandom);
			endcase
		end
	endtask

	initial begin
		logic [REG_W-1:0] rv, cv;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;

		// Directed part on the full-size grid left by reset.
		queue_request(CMD_WRITE, 63, 63, 1, 0, 0, 0);
		queue_request(CMD_WRITE, 11, 11, 1, 0, 0, 0);
		queue_request(CMD_SEARCH, 10, 10, 0, 12, 13, 0);
		queue_request(CMD_READ, 0, 0, 0, 0, 0, 0);
		queue_request(CMD_READ, 0, 0, 0, 0, 0, 5);
		queue_request(CMD_READ, 0, 0, 0, 0, 0, 12'hFFF);
		queue_request(CMD_BAD, 6'h3F, 6'h3F, 1, 6'h3F, 6'h3F, 12'hFFF);
		wait_drained();

		// One row, full width (a zero row count and an over-range column count).
		write_reg(REG_ROWS, 7'd0);
		write_reg(REG_COLS, 7'h7F);
		write_reg(REG_UNUSED, 7'd5);
		queue_request(CMD_WRITE, 1, 0, 0, 0, 0, 0);
		queue_request(CMD_SEARCH, 0, 0, 0, 1, 0, 0);
		// blocked start is still expanded
		queue_request(CMD_WRITE, 0, 0, 1, 0, 0, 0);
		queue_request(CMD_WRITE, 0, 1, 0, 0, 0, 0);
		queue_request(CMD_SEARCH, 0, 0, 0, 0, 2, 0);
		queue_request(CMD_READ, 0, 0, 0, 0, 0, 2);
		queue_request(CMD_READ, 0, 0, 0, 0, 0, 3);
		// blocked goal: never inserted, so no path
		queue_request(CMD_WRITE, 0, 1, 1, 0, 0, 0);
		// start equals goal: no path and the stored path is dropped
		queue_request(CMD_SEARCH, 0, 0, 0, 0, 0, 0);
		queue_request(CMD_READ, 0, 0, 0, 0, 0, 0);
		queue_request(CMD_SEARCH, 0, 0, 0, 0, 1, 0);
		queue_request(CMD_READ, 0, 0, 0, 0, 0, 0);
		queue_request(CMD_WRITE, 0, 1, 0, 0, 0, 0);
		wait_drained();

		for (int p = 0; p < NUM_PHASES; p++) begin
			rv = REG_W'(($urandom_range(0, 9) < 7) ? $urandom_range(1, 4) :
			            $urandom_range(0, 127));
			cv = REG_W'(($urandom_range(0, 9) < 7) ? $urandom_range(1, 4) :
			            $urandom_range(0, 127));
			write_reg(REG_ROWS, rv);
			write_reg(REG_COLS, cv);
			fill_phase(clamp_dim(rv), clamp_dim(cv));
			wait_drained();
		end

		repeat (100) @(posedge clk);
		if (mismatches == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

endmodule
